### rtl/fdtd_yee_grid_step_top_defines.svh
// ---------------------------------------------------------------------------
// fdtd_yee_grid_step_top_defines
// assertion macros shared by the grid step modules
// ---------------------------------------------------------------------------
`ifndef FDTD_YEE_GRID_STEP_TOP_DEFINES_SVH
`define FDTD_YEE_GRID_STEP_TOP_DEFINES_SVH
`ifndef SYNTHESIS
`define FYEE_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("fyee check failed");
`define FYEE_NEXT(lbl, clk, rst_n, cond, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error("fyee check failed");
`else
`define FYEE_ASSERT(lbl, clk, rst_n, prop)
`define FYEE_NEXT(lbl, clk, rst_n, cond, prop)
`endif
`endif

### rtl/fyee_pkg.sv
// ---------------------------------------------------------------------------
// fyee_pkg
// grid sizes, command codes and shared types of the yee grid step engine
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
package fyee_pkg;
    localparam int GRID_X        = 16;
    localparam int GRID_Y        = 16;
    localparam int GRID_Z        = 16;
    localparam int MAT_COUNT     = 8;
    localparam int CELLS         = GRID_X * GRID_Y * GRID_Z;
    localparam int CELL_W        = $clog2(CELLS);
    localparam int XW            = $clog2(GRID_X);
    localparam int YW            = $clog2(GRID_Y);
    localparam int ZW            = $clog2(GRID_Z);
    localparam int MAT_W         = $clog2(MAT_COUNT);
    localparam int NUM_COEF      = 8;
    localparam int DATA_W        = 32;
    localparam int NUM_FIELD     = 6;
    localparam int ACC_W         = 52;
    localparam logic [DATA_W-1:0] Q_ONE = 32'h0001_0000;
    localparam int CA_IDX        = 0;
    localparam int DA_IDX        = 4;

    localparam logic [2:0] CMD_WR_FIELD = 3'd0;
    localparam logic [2:0] CMD_WR_MAT   = 3'd1;
    localparam logic [2:0] CMD_WR_COEF  = 3'd2;
    localparam logic [2:0] CMD_STEP     = 3'd3;
    localparam logic [2:0] CMD_RD_FIELD = 3'd4;

    typedef logic [NUM_COEF-1:0][DATA_W-1:0] t_coef_row;

    typedef struct packed {
        logic [NUM_FIELD-1:0][CELL_W-1:0] addr;
        logic [NUM_FIELD-1:0]             we;
        logic [2:0][DATA_W-1:0]           wdata;
        logic [CELL_W-1:0]                mat_addr;
        logic [MAT_W-1:0]                 coef_addr;
    } t_eng_mem;

    function automatic logic [CELL_W-1:0] cell_addr(input int x, input int y, input int z);
        return CELL_W'((x * GRID_Y + y) * GRID_Z + z);
    endfunction
endpackage

### rtl/fyee_ram.sv
// ---------------------------------------------------------------------------
// fyee_ram
// single port synchronous ram, registered read
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
module fyee_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_q;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_q <= r_mem[i_addr];
    end

    assign o_rdata = r_q;
endmodule

### rtl/fyee_coef.sv
// ---------------------------------------------------------------------------
// fyee_coef
// coefficient table, one row of eight per material, per entry valid bits
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
module fyee_coef (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_we,
    input  logic [fyee_pkg::MAT_W-1:0]          i_wmat,
    input  logic [2:0]                          i_wsel,
    input  logic [fyee_pkg::DATA_W-1:0]         i_wdata,
    input  logic [fyee_pkg::MAT_W-1:0]          i_rmat,
    output fyee_pkg::t_coef_row                 o_row
);
    fyee_pkg::t_coef_row r_mem [fyee_pkg::MAT_COUNT];
    logic [fyee_pkg::MAT_COUNT-1:0][fyee_pkg::NUM_COEF-1:0] r_vld;
    fyee_pkg::t_coef_row                  r_q;
    logic [fyee_pkg::NUM_COEF-1:0]        r_qv;
    logic                                 r_q0;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_wmat][i_wsel] <= i_wdata;
        end
        r_q  <= r_mem[i_rmat];
        r_q0 <= (i_rmat == '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
            r_qv  <= '0;
        end else begin
            if (i_we) begin
                r_vld[i_wmat][i_wsel] <= 1'b1;
            end
            r_qv <= r_vld[i_rmat];
        end
    end

    always_comb begin
        for (int l = 0; l < fyee_pkg::NUM_COEF; l++) begin
            if (r_qv[l]) begin
                o_row[l] = r_q[l];
            end else if (r_q0 && (l == fyee_pkg::CA_IDX || l == fyee_pkg::DA_IDX)) begin
                o_row[l] = fyee_pkg::Q_ONE;
            end else begin
                o_row[l] = '0;
            end
        end
    end
endmodule

### rtl/fyee_seq.sv
// ---------------------------------------------------------------------------
// fyee_seq
// step sequencer: walks interior cells, e pass then h pass, one shared
// multiplier, read modify write of the field stores
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "fdtd_yee_grid_step_top_defines.svh"
module fyee_seq (
    input  logic                                                i_clk,
    input  logic                                                i_rst_n,
    input  logic                                                i_start,
    input  logic [fyee_pkg::NUM_FIELD-1:0][fyee_pkg::DATA_W-1:0] i_field_q,
    input  logic [fyee_pkg::MAT_W-1:0]                          i_mat_q,
    input  fyee_pkg::t_coef_row                                 i_coef_row,
    output fyee_pkg::t_eng_mem                                  o_mem,
    output logic                                                o_done
);
    typedef enum logic [7:0] {
        S_IDLE  = 8'b0000_0001,
        S_RD0   = 8'b0000_0010,
        S_RD1   = 8'b0000_0100,
        S_RD2   = 8'b0000_1000,
        S_RD3   = 8'b0001_0000,
        S_MUL   = 8'b0010_0000,
        S_DRAIN = 8'b0100_0000,
        S_WR    = 8'b1000_0000
    } t_state;

    localparam int ACC_W = fyee_pkg::ACC_W;

    t_state r_state, n_state;
    logic [fyee_pkg::XW-1:0] r_i;
    logic [fyee_pkg::YW-1:0] r_j;
    logic [fyee_pkg::ZW-1:0] r_k;
    logic                    r_phase_h;
    logic [1:0]              r_comp, r_term, r_pcomp, r_pterm;
    logic                    r_pv;
    logic [2:0][31:0]        r_old, r_own, r_n1, r_n2;
    fyee_pkg::t_coef_row     r_coef;
    logic signed [64:0]      r_prod;
    logic signed [ACC_W-1:0] r_acc [3];

    logic [fyee_pkg::CELL_W-1:0] w_c, w_p1, w_psy, w_psx;
    logic [2:0][fyee_pkg::CELL_W-1:0] w_oth_addr;
    logic [2:0][31:0]        w_upd_q, w_oth_q;
    logic [2:0]              w_ci;
    logic signed [32:0]      w_d;
    logic signed [31:0]      w_coef;
    logic signed [64:0]      w_prod;
    logic signed [ACC_W-1:0] w_term;
    logic                    w_last;

    function automatic logic signed [32:0] f_diff(input logic [31:0] a, input logic [31:0] b);
        return {a[31], a} - {b[31], b};
    endfunction

    function automatic logic [31:0] f_sat(input logic signed [ACC_W-1:0] v);
        if ((&v[ACC_W-1:31]) || !(|v[ACC_W-1:31])) begin
            return v[31:0];
        end else if (v[ACC_W-1]) begin
            return 32'h8000_0000;
        end else begin
            return 32'h7fff_ffff;
        end
    endfunction

    always_comb begin
        w_c   = fyee_pkg::cell_addr(int'(r_i), int'(r_j), int'(r_k));
        w_p1  = r_phase_h ? w_c + fyee_pkg::CELL_W'(1) : w_c - fyee_pkg::CELL_W'(1);
        w_psy = r_phase_h ? w_c + fyee_pkg::CELL_W'(fyee_pkg::GRID_Z)
                          : w_c - fyee_pkg::CELL_W'(fyee_pkg::GRID_Z);
        w_psx = r_phase_h ? w_c + fyee_pkg::CELL_W'(fyee_pkg::GRID_Y * fyee_pkg::GRID_Z)
                          : w_c - fyee_pkg::CELL_W'(fyee_pkg::GRID_Y * fyee_pkg::GRID_Z);
        if (r_state == S_RD1) begin
            w_oth_addr = {w_psy, w_p1, w_p1};
        end else if (r_state == S_RD2) begin
            w_oth_addr = {w_psx, w_psx, w_psy};
        end else begin
            w_oth_addr = {w_c, w_c, w_c};
        end
        for (int n = 0; n < 3; n++) begin
            w_upd_q[n] = r_phase_h ? i_field_q[n + 3] : i_field_q[n];
            w_oth_q[n] = r_phase_h ? i_field_q[n] : i_field_q[n + 3];
            o_mem.addr[n]     = r_phase_h ? w_oth_addr[n] : w_c;
            o_mem.addr[n + 3] = r_phase_h ? w_c : w_oth_addr[n];
            o_mem.we[n]       = (r_state == S_WR) && !r_phase_h;
            o_mem.we[n + 3]   = (r_state == S_WR) && r_phase_h;
            o_mem.wdata[n]    = f_sat(r_acc[n]);
        end
        o_mem.mat_addr  = w_c;
        o_mem.coef_addr = i_mat_q;
    end

    // operand select: decay term, then the two curl terms of each component
    always_comb begin
        w_ci = {r_phase_h, 2'd0};
        w_d  = f_diff(r_old[r_comp], 32'd0);
        if (r_term != 2'd0) begin
            case ({r_comp, r_term[1]})
                3'b000: begin w_ci = {r_phase_h, 2'd2}; w_d = f_diff(r_own[2], r_n1[2]); end
                3'b001: begin w_ci = {r_phase_h, 2'd3}; w_d = f_diff(r_n1[1], r_own[1]); end
                3'b010: begin w_ci = {r_phase_h, 2'd3}; w_d = f_diff(r_own[0], r_n1[0]); end
                3'b011: begin w_ci = {r_phase_h, 2'd1}; w_d = f_diff(r_n2[2], r_own[2]); end
                3'b100: begin w_ci = {r_phase_h, 2'd1}; w_d = f_diff(r_own[1], r_n2[1]); end
                3'b101: begin w_ci = {r_phase_h, 2'd2}; w_d = f_diff(r_n2[0], r_own[0]); end
                default: begin w_ci = {r_phase_h, 2'd0}; w_d = '0; end
            endcase
        end
        w_coef = r_coef[w_ci];
        w_prod = w_coef * w_d;
        w_term = ACC_W'(r_prod >>> 16);
        w_last = (r_i == fyee_pkg::XW'(fyee_pkg::GRID_X - 2))
              && (r_j == fyee_pkg::YW'(fyee_pkg::GRID_Y - 2))
              && (r_k == fyee_pkg::ZW'(fyee_pkg::GRID_Z - 2));
        o_done = (r_state == S_WR) && w_last && r_phase_h;
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:  if (i_start) n_state = S_RD0;
            S_RD0:   n_state = S_RD1;
            S_RD1:   n_state = S_RD2;
            S_RD2:   n_state = S_RD3;
            S_RD3:   n_state = S_MUL;
            S_MUL:   if (r_comp == 2'd2 && r_term == 2'd2) n_state = S_DRAIN;
            S_DRAIN: n_state = S_WR;
            S_WR:    n_state = (w_last && r_phase_h) ? S_IDLE : S_RD0;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_pv      <= 1'b0;
            r_phase_h <= 1'b0;
            r_i       <= fyee_pkg::XW'(1);
            r_j       <= fyee_pkg::YW'(1);
            r_k       <= fyee_pkg::ZW'(1);
            r_comp    <= '0;
            r_term    <= '0;
        end else begin
            r_state <= n_state;
            r_pv    <= (r_state == S_MUL);
            if (r_state == S_IDLE && i_start) begin
                r_phase_h <= 1'b0;
                r_i       <= fyee_pkg::XW'(1);
                r_j       <= fyee_pkg::YW'(1);
                r_k       <= fyee_pkg::ZW'(1);
            end
            if (r_state == S_RD3) begin
                r_comp <= '0;
                r_term <= '0;
            end
            if (r_state == S_MUL) begin
                if (r_term == 2'd2) begin
                    r_term <= '0;
                    r_comp <= r_comp + 2'd1;
                end else begin
                    r_term <= r_term + 2'd1;
                end
            end
            if (r_state == S_WR) begin
                if (w_last) begin
                    r_phase_h <= 1'b1;
                    r_i       <= fyee_pkg::XW'(1);
                    r_j       <= fyee_pkg::YW'(1);
                    r_k       <= fyee_pkg::ZW'(1);
                end else if (r_k != fyee_pkg::ZW'(fyee_pkg::GRID_Z - 2)) begin
                    r_k <= r_k + fyee_pkg::ZW'(1);
                end else begin
                    r_k <= fyee_pkg::ZW'(1);
                    if (r_j != fyee_pkg::YW'(fyee_pkg::GRID_Y - 2)) begin
                        r_j <= r_j + fyee_pkg::YW'(1);
                    end else begin
                        r_j <= fyee_pkg::YW'(1);
                        r_i <= r_i + fyee_pkg::XW'(1);
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_RD1) begin
            r_old <= w_upd_q;
            r_own <= w_oth_q;
        end
        if (r_state == S_RD2) begin
            r_n1   <= w_oth_q;
            r_coef <= i_coef_row;
        end
        if (r_state == S_RD3) begin
            r_n2 <= w_oth_q;
        end
        r_prod  <= w_prod;
        r_pcomp <= r_comp;
        r_pterm <= r_term;
        if (r_pv) begin
            r_acc[r_pcomp] <= (r_pterm == 2'd0) ? w_term : r_acc[r_pcomp] + w_term;
        end
    end

    `FYEE_ASSERT(a_start_idle, i_clk, i_rst_n, i_start |-> r_state == S_IDLE)
    `FYEE_NEXT(a_done_pulse, i_clk, i_rst_n, o_done, !o_done)
    `FYEE_NEXT(a_wr_single, i_clk, i_rst_n, r_state == S_WR, r_state != S_WR)
endmodule

### rtl/fdtd_yee_grid_step_top.sv
// ---------------------------------------------------------------------------
// fdtd_yee_grid_step_top
// 3d yee grid engine: six field stores, material map, coefficient table
// ---------------------------------------------------------------------------
// channel   | direction | handshake            | payload
// command   | in        | start high, busy low | i_cmd, i_cell_*, i_component,
//           |           |                      | i_mat_sel, i_coef_sel, i_data_value
// result    | out       | o_valid, one cycle   | o_read_value, o_status
//
// writes and reads take one item per cycle while not busy; a read answers in the next cycle
// a step walks (GRID_X-2)(GRID_Y-2)(GRID_Z-2) cells twice, e pass then h pass,
// paced by the shared multiplier and one port per store
// after reset a clearing pass over all GRID_X*GRID_Y*GRID_Z cells (4096) holds busy
// the receiver takes every result as it comes
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "fdtd_yee_grid_step_top_defines.svh"
module fdtd_yee_grid_step_top (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [2:0]         i_cmd,
    input  logic [3:0]         i_cell_x,
    input  logic [3:0]         i_cell_y,
    input  logic [3:0]         i_cell_z,
    input  logic [2:0]         i_component,
    input  logic [2:0]         i_mat_sel,
    input  logic [2:0]         i_coef_sel,
    input  logic signed [31:0] i_data_value,
    output logic signed [31:0] o_read_value,
    output logic               o_status,
    output logic               o_valid
);
    typedef enum logic [2:0] {
        T_CLEAR = 3'b001,
        T_IDLE  = 3'b010,
        T_STEP  = 3'b100
    } t_state;

    t_state r_state, n_state;
    logic [fyee_pkg::CELL_W-1:0] r_clr;
    logic                        r_out_valid, r_status, r_rd_pend;
    logic [2:0]                  r_rd_comp;

    logic w_acc, w_clear, w_step, w_inside, w_comp_ok, w_mat_ok, w_done, w_st;
    logic [fyee_pkg::CELL_W-1:0] w_addr;
    logic [fyee_pkg::NUM_FIELD-1:0][fyee_pkg::DATA_W-1:0] w_fq;
    logic [fyee_pkg::MAT_W-1:0]  w_mat_q;
    fyee_pkg::t_coef_row         w_coef_row;
    fyee_pkg::t_eng_mem          w_eng;

    assign busy      = (r_state != T_IDLE);
    assign w_acc     = start && !busy;
    assign w_clear   = (r_state == T_CLEAR);
    assign w_step    = (r_state == T_STEP);
    assign w_inside  = (int'(i_cell_x) < fyee_pkg::GRID_X) && (int'(i_cell_y) < fyee_pkg::GRID_Y)
                    && (int'(i_cell_z) < fyee_pkg::GRID_Z);
    assign w_comp_ok = (int'(i_component) < fyee_pkg::NUM_FIELD);
    assign w_mat_ok  = (int'(i_mat_sel) < fyee_pkg::MAT_COUNT);
    assign w_addr    = fyee_pkg::cell_addr(int'(i_cell_x), int'(i_cell_y), int'(i_cell_z));

    for (genvar g = 0; g < fyee_pkg::NUM_FIELD; g++) begin : g_field
        logic                        w_we;
        logic [fyee_pkg::CELL_W-1:0] w_a;
        logic [fyee_pkg::DATA_W-1:0] w_wd;
        always_comb begin
            w_we = w_clear || (w_step && w_eng.we[g])
                || (w_acc && i_cmd == fyee_pkg::CMD_WR_FIELD && w_inside
                    && int'(i_component) == g);
            w_a  = w_clear ? r_clr : (w_step ? w_eng.addr[g] : w_addr);
            w_wd = w_clear ? '0 : (w_step ? w_eng.wdata[g % 3] : i_data_value);
        end
        fyee_ram #(.WIDTH(fyee_pkg::DATA_W), .DEPTH(fyee_pkg::CELLS)) u_ram (
            .i_clk   (i_clk),
            .i_we    (w_we),
            .i_addr  (w_a),
            .i_wdata (w_wd),
            .o_rdata (w_fq[g])
        );
    end

    fyee_ram #(.WIDTH(fyee_pkg::MAT_W), .DEPTH(fyee_pkg::CELLS)) u_mat (
        .i_clk   (i_clk),
        .i_we    (w_clear || (w_acc && i_cmd == fyee_pkg::CMD_WR_MAT && w_inside && w_mat_ok)),
        .i_addr  (w_clear ? r_clr : (w_step ? w_eng.mat_addr : w_addr)),
        .i_wdata (w_clear ? '0 : i_mat_sel[fyee_pkg::MAT_W-1:0]),
        .o_rdata (w_mat_q)
    );

    fyee_coef u_coef (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (w_acc && i_cmd == fyee_pkg::CMD_WR_COEF && i_mat_sel != '0 && w_mat_ok),
        .i_wmat  (i_mat_sel[fyee_pkg::MAT_W-1:0]),
        .i_wsel  (i_coef_sel),
        .i_wdata (i_data_value),
        .i_rmat  (w_eng.coef_addr),
        .o_row   (w_coef_row)
    );

    fyee_seq u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_acc && i_cmd == fyee_pkg::CMD_STEP),
        .i_field_q  (w_fq),
        .i_mat_q    (w_mat_q),
        .i_coef_row (w_coef_row),
        .o_mem      (w_eng),
        .o_done     (w_done)
    );

    always_comb begin
        unique case (i_cmd)
            fyee_pkg::CMD_WR_FIELD: w_st = !(w_inside && w_comp_ok);
            fyee_pkg::CMD_WR_MAT:   w_st = !(w_inside && w_mat_ok);
            fyee_pkg::CMD_WR_COEF:  w_st = !(i_mat_sel != '0 && w_mat_ok);
            default:                w_st = 1'b0;
        endcase
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            T_CLEAR: if (r_clr == fyee_pkg::CELL_W'(fyee_pkg::CELLS - 1)) n_state = T_IDLE;
            T_IDLE:  if (w_acc && i_cmd == fyee_pkg::CMD_STEP) n_state = T_STEP;
            T_STEP:  if (w_done) n_state = T_IDLE;
            default: n_state = T_CLEAR;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= T_CLEAR;
            r_clr       <= '0;
            r_out_valid <= 1'b0;
            r_status    <= 1'b0;
            r_rd_pend   <= 1'b0;
        end else begin
            r_state     <= n_state;
            if (w_clear) begin
                r_clr <= r_clr + fyee_pkg::CELL_W'(1);
            end
            r_out_valid <= (w_acc && i_cmd != fyee_pkg::CMD_STEP) || w_done;
            r_status    <= w_acc && w_st;
            r_rd_pend   <= w_acc && i_cmd == fyee_pkg::CMD_RD_FIELD && w_inside && w_comp_ok;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_comp <= i_component;
    end

    assign o_valid      = r_out_valid;
    assign o_status     = r_status;
    assign o_read_value = r_rd_pend ? $signed(w_fq[r_rd_comp]) : '0;

    `FYEE_ASSERT(a_done_in_step, i_clk, i_rst_n, w_done |-> w_step)
    `FYEE_NEXT(a_step_enters, i_clk, i_rst_n, w_acc && i_cmd == fyee_pkg::CMD_STEP, w_step)
    `FYEE_NEXT(a_item_answer, i_clk, i_rst_n, w_acc && i_cmd != fyee_pkg::CMD_STEP, o_valid)
endmodule
